/* sv/rbd_pkg.sv */
package rbd_pkg;

  // Patch geometry and descriptor length
  localparam int PATCH_SIDE      = 64;
  localparam int DESCRIPTOR_BITS = 256;
  localparam int STORE_DEPTH     = 4096;
  localparam int ADDR_W          = 12;
  localparam int PIX_W           = 8;
  localparam int OFS_W           = 6;
  localparam int TRIG_W          = 16;
  localparam int FRAC_BITS       = 14;

  // Rotation datapath widths
  localparam int PROD_W  = OFS_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int COORD_W = $clog2(PATCH_SIDE);
  localparam int ADDR_CALC_W = (2 * COORD_W + 1 > ADDR_W) ? 2 * COORD_W + 1 : ADDR_W;

  // Descriptor byte bookkeeping
  localparam int NBYTES_RAW = DESCRIPTOR_BITS / 8;
  localparam int NBYTES     = (NBYTES_RAW < 1) ? 1 : NBYTES_RAW;
  localparam int BCNT_W     = ($clog2(NBYTES) > 5) ? $clog2(NBYTES) : 5;
  localparam int IDX_W      = 5;
  localparam logic [BCNT_W-1:0] LAST_BYTE = BCNT_W'(NBYTES - 1);

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int CRED_W  = Q_CNT_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TRIG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_SIN = 1'b0,
    REG_ROT_COS = 1'b1
  } rbd_reg_e;

  localparam logic signed [TRIG_W-1:0] ROT_SIN_RST = TRIG_W'(0);
  localparam logic signed [TRIG_W-1:0] ROT_COS_RST = TRIG_W'(1 << FRAC_BITS);

  // One decoded command as handed from front to back
  typedef struct packed {
    logic              is_test;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [PIX_W-1:0]  value;
  } rbd_cmd_t;

  // Rounding offsets: half away from zero in one add, then arithmetic shift
  localparam logic signed [SUM_W:0] HALF_UP = (SUM_W + 1)'(1 << (FRAC_BITS - 1));
  localparam logic signed [SUM_W:0] HALF_DN = (SUM_W + 1)'((1 << (FRAC_BITS - 1)) - 1);
  localparam logic signed [SUM_W:0] CENTRE  = (SUM_W + 1)'(PATCH_SIDE / 2);
  localparam logic signed [SUM_W:0] EDGE_HI = (SUM_W + 1)'(PATCH_SIDE - 1);

  // Q14 rotated offset -> rounded, centred, clamped coordinate
  function automatic logic [COORD_W-1:0] rbd_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W:0] t;
    logic signed [SUM_W:0] pos;
    logic [COORD_W-1:0]    res;
    t   = $signed({v[SUM_W-1], v}) + (v[SUM_W-1] ? HALF_DN : HALF_UP);
    pos = (t >>> FRAC_BITS) + CENTRE;
    priority if (pos < 0) res = '0;
    else if (pos > EDGE_HI) res = COORD_W'(PATCH_SIDE - 1);
    else res = pos[COORD_W-1:0];
    return res;
  endfunction

  // Store address row*side+col, wrapped to the store depth
  function automatic logic [ADDR_W-1:0] rbd_addr(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
    logic [ADDR_CALC_W-1:0] a;
    a = ADDR_CALC_W'(row) * ADDR_CALC_W'(PATCH_SIDE) + ADDR_CALC_W'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

/* sv/rbd_item_if.sv */
interface rbd_item_if;
  import rbd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [ADDR_W-1:0]       pixel_addr;
  logic [PIX_W-1:0]        pixel_value;
  logic signed [OFS_W-1:0] left_x;
  logic signed [OFS_W-1:0] left_y;
  logic signed [OFS_W-1:0] right_x;
  logic signed [OFS_W-1:0] right_y;

  modport source (output valid, op, pixel_addr, pixel_value, left_x, left_y, right_x,
                  right_y, input ready);
  modport sink (input valid, op, pixel_addr, pixel_value, left_x, left_y, right_x,
                right_y, output ready);
endinterface

/* sv/rbd_desc_if.sv */
interface rbd_desc_if;
  import rbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] descriptor_byte;
  logic [IDX_W-1:0] byte_index;
  logic             last;

  modport source (output valid, descriptor_byte, byte_index, last, input ready);
  modport sink (input valid, descriptor_byte, byte_index, last, output ready);
endinterface

/* sv/rotated_brief_descriptor.sv */
// Channel   Role     Beat contents
// item      sink     op, pixel_addr, pixel_value, left_x, left_y, right_x, right_y
// desc      source   descriptor_byte, byte_index, last
// cfg       write    cfg_we, cfg_index (0 rot_sin, 1 rot_cos), cfg_data
//
// One item per cycle sustained: the front takes a beat every cycle while the
// four-entry command queue has room for it and the two beats in the rotation pipe.
// An item beat passes the products, sums, queue, patch store read and output
// register on its way to a descriptor byte.
// Reset clears control state only; patch pixels are undefined until written.
// A stalled desc holds the read stage, then the queue, then item.ready.
module rotated_brief_descriptor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  rbd_item_if.sink                       item,
  rbd_desc_if.source                     desc
);
  import rbd_pkg::*;

  logic               push;
  rbd_cmd_t           push_cmd;
  logic               pop;
  logic               head_valid;
  rbd_cmd_t           head_cmd;
  logic [Q_CNT_W-1:0] q_count;

  rbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .q_count   (q_count),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .count      (q_count)
  );

  rbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .desc       (desc)
  );

endmodule

/* sv/rbd_front.sv */
module rbd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  rbd_item_if.sink                        item,
  input  logic [rbd_pkg::Q_CNT_W-1:0]     q_count,
  output logic                            push,
  output rbd_pkg::rbd_cmd_t               push_cmd
);
  import rbd_pkg::*;

  logic signed [TRIG_W-1:0] rot_sin;
  logic signed [TRIG_W-1:0] rot_cos;

  // stage 1: products
  logic                     s1_v;
  logic                     s1_op;
  logic [ADDR_W-1:0]        s1_addr;
  logic [PIX_W-1:0]         s1_value;
  logic signed [PROD_W-1:0] p_lxs, p_lyc, p_lxc, p_lys;
  logic signed [PROD_W-1:0] p_rxs, p_ryc, p_rxc, p_rys;

  // stage 2: rotated sums
  logic                    s2_v;
  logic                    s2_op;
  logic [ADDR_W-1:0]       s2_addr;
  logic [PIX_W-1:0]        s2_value;
  logic signed [SUM_W-1:0] l_row, l_col, r_row, r_col;

  logic accept;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_sin <= ROT_SIN_RST;
      rot_cos <= ROT_COS_RST;
    end else if (cfg_we) begin
      unique case (rbd_reg_e'(cfg_index))
        REG_ROT_SIN: rot_sin <= cfg_data;
        REG_ROT_COS: rot_cos <= cfg_data;
      endcase
    end
  end

  // credit check: queue entries plus beats still in the pipe
  assign item.ready = (CRED_W'(q_count) + CRED_W'(s1_v) + CRED_W'(s2_v)) < CRED_W'(Q_DEPTH);
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    s1_op    <= item.op;
    s1_addr  <= item.pixel_addr;
    s1_value <= item.pixel_value;
    p_lxs    <= PROD_W'(item.left_x)  * PROD_W'(rot_sin);
    p_lyc    <= PROD_W'(item.left_y)  * PROD_W'(rot_cos);
    p_lxc    <= PROD_W'(item.left_x)  * PROD_W'(rot_cos);
    p_lys    <= PROD_W'(item.left_y)  * PROD_W'(rot_sin);
    p_rxs    <= PROD_W'(item.right_x) * PROD_W'(rot_sin);
    p_ryc    <= PROD_W'(item.right_y) * PROD_W'(rot_cos);
    p_rxc    <= PROD_W'(item.right_x) * PROD_W'(rot_cos);
    p_rys    <= PROD_W'(item.right_y) * PROD_W'(rot_sin);
  end

  // stage 2 payload: row = x*sin + y*cos, col = x*cos - y*sin
  always_ff @(posedge clk) begin
    s2_op    <= s1_op;
    s2_addr  <= s1_addr;
    s2_value <= s1_value;
    l_row    <= $signed({p_lxs[PROD_W-1], p_lxs}) + $signed({p_lyc[PROD_W-1], p_lyc});
    l_col    <= $signed({p_lxc[PROD_W-1], p_lxc}) - $signed({p_lys[PROD_W-1], p_lys});
    r_row    <= $signed({p_rxs[PROD_W-1], p_rxs}) + $signed({p_ryc[PROD_W-1], p_ryc});
    r_col    <= $signed({p_rxc[PROD_W-1], p_rxc}) - $signed({p_rys[PROD_W-1], p_rys});
  end

  // round, clamp and form store addresses on the way into the queue; a write keeps its pixel_addr
  always_comb begin
    push_cmd.is_test = s2_op;
    push_cmd.value   = s2_value;
    push_cmd.addr_b  = rbd_addr(rbd_coord(r_row), rbd_coord(r_col));
    if (s2_op) begin
      push_cmd.addr_a = rbd_addr(rbd_coord(l_row), rbd_coord(l_col));
    end else begin
      push_cmd.addr_a = s2_addr;
    end
  end

  assign push = s2_v;

endmodule

/* sv/rbd_queue.sv */
module rbd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  rbd_pkg::rbd_cmd_t           push_cmd,
  input  logic                        pop,
  output logic                        head_valid,
  output rbd_pkg::rbd_cmd_t           head_cmd,
  output logic [rbd_pkg::Q_CNT_W-1:0] count
);
  import rbd_pkg::*;

  rbd_cmd_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

endmodule

/* sv/rbd_back.sv */
module rbd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  rbd_pkg::rbd_cmd_t head_cmd,
  output logic              pop,
  rbd_desc_if.source        desc
);
  import rbd_pkg::*;

  logic [PIX_W-1:0] patch_mem [STORE_DEPTH];

  // read stage
  logic             rd_v;
  logic [PIX_W-1:0] rd_a;
  logic [PIX_W-1:0] rd_b;

  // bit packing
  logic [PIX_W-1:0]  bit_acc;
  logic [2:0]        bit_count;
  logic [BCNT_W-1:0] byte_cnt;
  logic              test_bit;
  logic              stall;
  logic              emit;
  logic [PIX_W-1:0]  acc_next;

  // output register
  logic             out_v;
  logic [PIX_W-1:0] out_byte;
  logic [IDX_W-1:0] out_idx;
  logic             out_last;

  // a finished byte that cannot load the output register holds the read stage
  assign stall    = rd_v && (bit_count == 3'd7) && out_v && !desc.ready;
  assign emit     = rd_v && (bit_count == 3'd7) && !stall;
  assign pop      = head_valid && !stall;
  assign test_bit = rd_a < rd_b;
  assign acc_next = bit_acc | (PIX_W'(test_bit) << bit_count);

  // patch store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pop && !head_cmd.is_test) patch_mem[head_cmd.addr_a] <= head_cmd.value;
  end

  always_ff @(posedge clk) begin
    if (pop) rd_a <= patch_mem[head_cmd.addr_a];
  end

  always_ff @(posedge clk) begin
    if (pop) rd_b <= patch_mem[head_cmd.addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else if (!stall) begin
      rd_v <= pop && head_cmd.is_test;
    end
  end

  // accumulate test bits, wrap at the end of a descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_acc   <= '0;
      bit_count <= '0;
      byte_cnt  <= '0;
    end else if (rd_v && !stall) begin
      if (bit_count == 3'd7) begin
        bit_acc   <= '0;
        bit_count <= '0;
        byte_cnt  <= (byte_cnt >= LAST_BYTE) ? '0 : byte_cnt + 1'b1;
      end else begin
        bit_acc   <= acc_next;
        bit_count <= bit_count + 1'b1;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (emit) begin
      out_v <= 1'b1;
    end else if (desc.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= acc_next;
      out_idx  <= byte_cnt[IDX_W-1:0];
      out_last <= (byte_cnt >= LAST_BYTE);
    end
  end

  assign desc.valid           = out_v;
  assign desc.descriptor_byte = out_byte;
  assign desc.byte_index      = out_idx;
  assign desc.last            = out_last;

endmodule

/* sv/rbd_checker.sv */
module rbd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       desc_valid,
  input logic                       desc_ready,
  input logic [rbd_pkg::PIX_W-1:0]  desc_byte,
  input logic [rbd_pkg::IDX_W-1:0]  desc_index,
  input logic                       desc_last
);
  import rbd_pkg::*;

  // a waiting beat stays
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    desc_valid && !desc_ready |=> desc_valid)
    else $error("desc beat dropped while stalled");

  // a waiting beat keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    desc_valid && !desc_ready |=> $stable(desc_byte) && $stable(desc_index)
                                  && $stable(desc_last))
    else $error("desc payload changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !desc_valid)
    else $error("desc beat right after reset");

  // last flag only on the final byte position
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    desc_valid && desc_last |-> desc_index == LAST_BYTE[IDX_W-1:0])
    else $error("last flag on wrong byte index");

endmodule

bind rotated_brief_descriptor rbd_checker u_rbd_checker (
  .clk        (clk),
  .rst        (rst),
  .desc_valid (desc.valid),
  .desc_ready (desc.ready),
  .desc_byte  (desc.descriptor_byte),
  .desc_index (desc.byte_index),
  .desc_last  (desc.last)
);
